// File: hw/rtl/hrfs_pkg.sv
// Shared types, codes and helpers of the hopping receiver frame-sync sequencer.
package hrfs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CFG_BOUND_ID_LO    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_ID_HI    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_TIMEOUT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MISSING    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TELEM_DELAY    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_POWER_THRESH   = 3'd5;

  localparam logic [19:0] SYNC_TIMEOUT_RST  = 20'd9000;
  localparam logic [7:0]  MAX_MISSING_RST   = 8'd50;
  localparam logic [13:0] TELEM_DELAY_RST   = 14'd1500;
  localparam logic [7:0]  POWER_THRESH_RST  = 8'd110;

  localparam logic [6:0] FRAME_BYTES    = 7'd20;
  localparam logic [7:0] FRAME_LEN_CODE = 8'h11;
  localparam logic [7:0] SLOT_WRAP      = 8'd188;
  localparam logic [7:0] ANT_SWITCH_MIN = 8'd2;
  localparam logic [7:0] MISS_MAX       = 8'd255;
  localparam logic [1:0] TELEM_SLOT     = 2'd2;

  localparam logic [2:0] PWR_STRONG = 3'd5;
  localparam logic [2:0] PWR_WEAK   = 3'd6;
  localparam logic [2:0] PWR_NONE   = 3'd0;

  typedef enum logic [2:0] {
    PH_STARTING  = 3'd0,
    PH_UPDATE    = 3'd1,
    PH_DATA      = 3'd2,
    PH_TELEMETRY = 3'd3,
    PH_RESUME    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    TM_50X = 2'd0,
    TM_1X  = 2'd1,
    TM_10X = 2'd2
  } tmode_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START_RX  = 3'd1,
    ACT_RESTART   = 3'd2,
    ACT_HOP_RX    = 3'd3,
    ACT_HOP_ONLY  = 3'd4,
    ACT_TELEMETRY = 3'd5
  } action_e;

  typedef struct packed {
    logic [31:0] now_us;
    logic [6:0]  fifo_bytes;
    logic [7:0]  frame_length;
    logic [7:0]  frame_id_lo;
    logic [7:0]  frame_id_hi;
    logic [7:0]  frame_counter;
    logic        crc_ok;
    logic        radio_idle;
    logic [7:0]  link_rssi;
  } in_item_t;

  typedef struct packed {
    logic [2:0] radio_action;
    logic [2:0] tx_power_level;
    logic       flush_overflows;
    logic       read_frame;
    logic       frame_accepted;
    logic       counter_resync;
    logic       frame_lost;
    logic       switch_antenna;
    logic       failsafe_set;
  } out_item_t;

  typedef struct packed {
    logic [31:0] now_us;
    logic        fifo_ok;
    logic        frame_ok;
    logic        telem_slot;
    logic [7:0]  frame_counter;
    logic        radio_idle;
    logic [7:0]  link_rssi;
  } cmd_t;

  typedef struct packed {
    logic [19:0] sync_timeout_us;
    logic [7:0]  max_missing_frames;
    logic [13:0] telemetry_delay_us;
    logic [7:0]  power_rssi_threshold;
  } back_cfg_t;

  function automatic logic [7:0] bump_idx(logic [7:0] v);
    return (v >= SLOT_WRAP) ? SLOT_WRAP : v + 8'd1;
  endfunction

endpackage

// File: hw/rtl/hrfs_front.sv
// Front end: accepts polls and classifies the frame header independent of link state.
module hrfs_front import hrfs_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic [7:0] bound_id_lo_i,
  input  logic [7:0] bound_id_hi_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.now_us        = in_data_i.now_us;
    cmd_o.fifo_ok       = in_data_i.fifo_bytes >= FRAME_BYTES;
    cmd_o.frame_ok      = (in_data_i.frame_length == FRAME_LEN_CODE) && in_data_i.crc_ok &&
                          (in_data_i.frame_id_lo == bound_id_lo_i) &&
                          (in_data_i.frame_id_hi == bound_id_hi_i);
    cmd_o.telem_slot    = in_data_i.frame_counter[1:0] == TELEM_SLOT;
    cmd_o.frame_counter = in_data_i.frame_counter;
    cmd_o.radio_idle    = in_data_i.radio_idle;
    cmd_o.link_rssi     = in_data_i.link_rssi;
  end

endmodule

// File: hw/rtl/hrfs_queue.sv
// Two-entry queue of classified polls between the front and back ends.
module hrfs_queue import hrfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       wr_ptr_d;
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] count_q;
  logic [1:0] count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/hrfs_back.sv
// Back end: link state machine, timeout checks and the registered result stage.
module hrfs_back import hrfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  back_cfg_t cfg_i,
  input  logic      q_empty_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e      ph_q;
  phase_e      ph_d;
  logic [31:0] last_q;
  logic [31:0] last_d;
  logic [7:0]  idx_q;
  logic [7:0]  idx_d;
  logic [7:0]  miss_q;
  logic [7:0]  miss_d;
  tmode_e      tm_q;
  tmode_e      tm_d;
  logic [7:0]  held_q;
  logic [7:0]  held_d;
  logic        out_valid_q;
  out_item_t   out_data_q;
  out_item_t   res;

  logic [25:0] lim50_q;
  logic [23:0] lim10_q;
  logic [31:0] delta_base;
  logic [31:0] lt_w;
  logic [31:0] delta_w;
  logic [7:0]  e0_w;
  logic [7:0]  e1_w;
  logic [7:0]  miss_w;
  tmode_e      tm_w;
  logic [25:0] lim_w;
  logic        acc_w;
  logic        resync_w;

  assign pop_o       = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign delta_base  = cmd_i.now_us - last_q;

  // Scaled timeouts, 50x and 10x the sync timeout, registered from the configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim50_q <= 26'd450000;
      lim10_q <= 24'd90000;
    end else begin
      lim50_q <= {1'b0, cfg_i.sync_timeout_us, 5'd0} + {2'b0, cfg_i.sync_timeout_us, 4'd0} +
                 {5'b0, cfg_i.sync_timeout_us, 1'b0};
      lim10_q <= {1'b0, cfg_i.sync_timeout_us, 3'd0} + {3'b0, cfg_i.sync_timeout_us, 1'b0};
    end
  end

  always_comb begin
    ph_d     = ph_q;
    last_d   = last_q;
    idx_d    = idx_q;
    miss_d   = miss_q;
    tm_d     = tm_q;
    held_d   = held_q;
    res      = '0;
    lt_w     = last_q;
    delta_w  = '0;
    e0_w     = idx_q;
    e1_w     = idx_q;
    miss_w   = miss_q;
    tm_w     = tm_q;
    lim_w    = '0;
    acc_w    = 1'b0;
    resync_w = 1'b0;
    unique case (ph_q)
      PH_RESUME: begin
        if (cmd_i.radio_idle) begin
          res.flush_overflows = 1'b1;
          res.radio_action    = ACT_RESTART;
        end
        if (delta_base > {12'd0, cfg_i.sync_timeout_us}) begin
          idx_d = bump_idx(idx_q);
          ph_d  = PH_UPDATE;
        end
      end
      PH_TELEMETRY: begin
        if (delta_base >= {18'd0, cfg_i.telemetry_delay_us}) begin
          res.radio_action   = ACT_TELEMETRY;
          res.tx_power_level = (held_q > cfg_i.power_rssi_threshold) ? PWR_STRONG : PWR_WEAK;
          ph_d               = PH_RESUME;
        end
      end
      PH_UPDATE, PH_DATA: begin
        ph_d = PH_DATA;
        if (ph_q == PH_UPDATE) begin
          lt_w = cmd_i.now_us;
        end
        acc_w          = cmd_i.fifo_ok && cmd_i.frame_ok;
        res.read_frame = cmd_i.fifo_ok;
        if (acc_w) begin
          e0_w     = (idx_q >= SLOT_WRAP) ? 8'd0 : idx_q;
          resync_w = cmd_i.frame_counter != e0_w;
          e1_w     = bump_idx(resync_w ? cmd_i.frame_counter : e0_w);
          lt_w     = cmd_i.now_us;
          tm_w     = TM_1X;
          miss_w   = 8'd0;
          res.frame_accepted = 1'b1;
          res.counter_resync = resync_w;
          if (cmd_i.telem_slot) begin
            res.radio_action = ACT_HOP_ONLY;
            held_d           = cmd_i.link_rssi;
            ph_d             = PH_TELEMETRY;
          end else begin
            res.radio_action = ACT_HOP_RX;
            ph_d             = PH_UPDATE;
          end
        end
        res.flush_overflows = 1'b1;
        delta_w = cmd_i.now_us - lt_w;
        case (tm_w)
          TM_50X:  lim_w = lim50_q;
          TM_10X:  lim_w = {2'd0, lim10_q};
          default: lim_w = {6'd0, cfg_i.sync_timeout_us};
        endcase
        last_d = lt_w;
        idx_d  = e1_w;
        miss_d = miss_w;
        tm_d   = tm_w;
        if (delta_w >= {6'd0, lim_w}) begin
          res.switch_antenna = miss_w >= ANT_SWITCH_MIN;
          if (miss_w >= cfg_i.max_missing_frames) begin
            tm_d              = TM_10X;
            res.failsafe_set  = 1'b1;
          end
          res.frame_lost   = 1'b1;
          miss_d           = (miss_w < MISS_MAX) ? miss_w + 8'd1 : miss_w;
          res.radio_action = ACT_RESTART;
          idx_d            = bump_idx(e1_w);
          ph_d             = PH_UPDATE;
          last_d           = cmd_i.now_us;
        end
      end
      default: begin
        res.radio_action = ACT_START_RX;
        ph_d             = PH_UPDATE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_STARTING;
      last_q      <= '0;
      idx_q       <= '0;
      miss_q      <= '0;
      tm_q        <= TM_50X;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ph_q   <= ph_d;
        last_q <= last_d;
        idx_q  <= idx_d;
        miss_q <= miss_d;
        tm_q   <= tm_d;
        held_q <= held_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= res;
    end
  end

endmodule

// File: hw/rtl/hopping_rx_frame_sync_fsm.sv
// Top level of the hopping receiver frame-sync sequencer.
//
// One poll enters on the input channel (in_valid_i, in_stall_o, in_data_i) and
// exactly one result leaves on the output channel (out_valid_o, out_stall_i,
// out_data_o). A transfer happens at a rising edge with valid high and stall low.
// Throughput is one poll per cycle while the receiver does not stall; the link
// state is read and updated by a single step of the back-end state machine per
// poll. A two-entry queue separates header classification from the state
// machine, and a result register holds a result while the receiver stalls.
// With the queue full, in_stall_o is raised until the receiver takes results
// again. Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must do so only while the block is idle, and the block itself
// does not enforce it. Indexes beyond the register list are ignored. Reset
// puts the link in the starting phase with the 50x timeout, clears the time,
// index and lost-frame count, and loads the register defaults.
module hopping_rx_frame_sync_fsm import hrfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [7:0] bound_id_lo_q;
  logic [7:0] bound_id_hi_q;
  back_cfg_t  cfg_q;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_id_lo_q              <= '0;
      bound_id_hi_q              <= '0;
      cfg_q.sync_timeout_us      <= SYNC_TIMEOUT_RST;
      cfg_q.max_missing_frames   <= MAX_MISSING_RST;
      cfg_q.telemetry_delay_us   <= TELEM_DELAY_RST;
      cfg_q.power_rssi_threshold <= POWER_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOUND_ID_LO:  bound_id_lo_q              <= cfg_data_i[7:0];
        CFG_BOUND_ID_HI:  bound_id_hi_q              <= cfg_data_i[7:0];
        CFG_SYNC_TIMEOUT: cfg_q.sync_timeout_us      <= cfg_data_i;
        CFG_MAX_MISSING:  cfg_q.max_missing_frames   <= cfg_data_i[7:0];
        CFG_TELEM_DELAY:  cfg_q.telemetry_delay_us   <= cfg_data_i[13:0];
        CFG_POWER_THRESH: cfg_q.power_rssi_threshold <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  hrfs_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .bound_id_lo_i (bound_id_lo_q),
    .bound_id_hi_i (bound_id_hi_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  hrfs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  hrfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/hrfs_checker.sv
// Port-level checker for the frame-sync sequencer and its bind to the top level.
module hrfs_checker import hrfs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed or dropped.");

  a_power_with_telemetry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.radio_action == ACT_TELEMETRY) ==
                     (out_data_o.tx_power_level != PWR_NONE)))
    else $error("Transmit power does not match the telemetry action.");

  a_accept_needs_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_accepted |-> out_data_o.read_frame &&
      out_data_o.flush_overflows)
    else $error("Frame accepted without a frame read.");

  a_resync_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.counter_resync |-> out_data_o.frame_accepted)
    else $error("Counter resync without an accepted frame.");

  a_loss_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.failsafe_set || out_data_o.switch_antenna) |->
      out_data_o.frame_lost && (out_data_o.radio_action == ACT_RESTART))
    else $error("Antenna switch or failsafe without a lost frame.");

endmodule

bind hopping_rx_frame_sync_fsm hrfs_checker u_hrfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: verif/hrfs_link_checker.sv
// Checker that predicts each result of the frame-sync sequencer and compares it on transfer.
`timescale 1ns / 1ps
module hrfs_link_checker import hrfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [7:0]  id_lo_q;
  logic [7:0]  id_hi_q;
  logic [19:0] sync_q;
  logic [7:0]  miss_limit_q;
  logic [13:0] delay_q;
  logic [7:0]  thresh_q;

  phase_e      phase_q;
  logic [31:0] last_evt_q;
  logic [7:0]  slot_q;
  logic [7:0]  missed_q;
  tmode_e      tmode_q;
  logic [7:0]  held_rssi_q;

  out_item_t   awaited_results[$];
  out_item_t   want;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      report_mismatch($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, got_v));
    end
  endtask

  function automatic logic [7:0] next_slot(logic [7:0] v);
    return (v >= SLOT_WRAP) ? SLOT_WRAP : v + 8'd1;
  endfunction

  function automatic logic [31:0] lost_limit();
    case (tmode_q)
      TM_50X:  return 32'(sync_q) * 32'd50;
      TM_10X:  return 32'(sync_q) * 32'd10;
      default: return 32'(sync_q);
    endcase
  endfunction

  function automatic out_item_t advance_link(in_item_t p);
    out_item_t   r;
    logic [31:0] elapsed;
    r = '0;
    elapsed = p.now_us - last_evt_q;
    case (phase_q)
      PH_RESUME: begin
        if (p.radio_idle) begin
          r.flush_overflows = 1'b1;
          r.radio_action = ACT_RESTART;
        end
        if (elapsed > 32'(sync_q)) begin
          slot_q = next_slot(slot_q);
          phase_q = PH_UPDATE;
        end
      end
      PH_TELEMETRY: begin
        if (elapsed >= 32'(delay_q)) begin
          r.radio_action = ACT_TELEMETRY;
          r.tx_power_level = (held_rssi_q > thresh_q) ? PWR_STRONG : PWR_WEAK;
          phase_q = PH_RESUME;
        end
      end
      PH_UPDATE, PH_DATA: begin
        if (phase_q == PH_UPDATE) begin
          phase_q = PH_DATA;
          last_evt_q = p.now_us;
        end
        if (p.fifo_bytes >= FRAME_BYTES) begin
          r.read_frame = 1'b1;
          if (p.frame_length == FRAME_LEN_CODE && p.crc_ok &&
              p.frame_id_lo == id_lo_q && p.frame_id_hi == id_hi_q) begin
            if (slot_q >= SLOT_WRAP) slot_q = '0;
            if (p.frame_counter != slot_q) begin
              r.counter_resync = 1'b1;
              slot_q = p.frame_counter;
            end
            if (p.frame_counter[1:0] == TELEM_SLOT) begin
              r.radio_action = ACT_HOP_ONLY;
              held_rssi_q = p.link_rssi;
              phase_q = PH_TELEMETRY;
            end else begin
              r.radio_action = ACT_HOP_RX;
              phase_q = PH_UPDATE;
            end
            last_evt_q = p.now_us;
            tmode_q = TM_1X;
            missed_q = '0;
            slot_q = next_slot(slot_q);
            r.frame_accepted = 1'b1;
          end
        end
        r.flush_overflows = 1'b1;
        elapsed = p.now_us - last_evt_q;
        if (elapsed >= lost_limit()) begin
          if (missed_q >= ANT_SWITCH_MIN) r.switch_antenna = 1'b1;
          if (missed_q >= miss_limit_q) begin
            tmode_q = TM_10X;
            r.failsafe_set = 1'b1;
          end
          r.frame_lost = 1'b1;
          if (missed_q != MISS_MAX) missed_q++;
          r.radio_action = ACT_RESTART;
          slot_q = next_slot(slot_q);
          phase_q = PH_UPDATE;
          last_evt_q = p.now_us;
        end
      end
      default: begin
        r.radio_action = ACT_START_RX;
        phase_q = PH_UPDATE;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_lo_q = '0;
      id_hi_q = '0;
      sync_q = SYNC_TIMEOUT_RST;
      miss_limit_q = MAX_MISSING_RST;
      delay_q = TELEM_DELAY_RST;
      thresh_q = POWER_THRESH_RST;
      phase_q = PH_STARTING;
      last_evt_q = '0;
      slot_q = '0;
      missed_q = '0;
      tmode_q = TM_50X;
      held_rssi_q = '0;
      awaited_results.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOUND_ID_LO:  id_lo_q = cfg_data_i[7:0];
          CFG_BOUND_ID_HI:  id_hi_q = cfg_data_i[7:0];
          CFG_SYNC_TIMEOUT: sync_q = cfg_data_i[19:0];
          CFG_MAX_MISSING:  miss_limit_q = cfg_data_i[7:0];
          CFG_TELEM_DELAY:  delay_q = cfg_data_i[13:0];
          CFG_POWER_THRESH: thresh_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with none awaited", out_data_i));
        end else begin
          want = awaited_results.pop_front();
          check_field("radio_action", want.radio_action, out_data_i.radio_action);
          check_field("tx_power_level", want.tx_power_level, out_data_i.tx_power_level);
          check_field("flush_overflows", want.flush_overflows, out_data_i.flush_overflows);
          check_field("read_frame", want.read_frame, out_data_i.read_frame);
          check_field("frame_accepted", want.frame_accepted, out_data_i.frame_accepted);
          check_field("counter_resync", want.counter_resync, out_data_i.counter_resync);
          check_field("frame_lost", want.frame_lost, out_data_i.frame_lost);
          check_field("switch_antenna", want.switch_antenna, out_data_i.switch_antenna);
          check_field("failsafe_set", want.failsafe_set, out_data_i.failsafe_set);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(advance_link(in_data_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top that drives polls and register writes into the frame-sync sequencer.
`timescale 1ns / 1ps
module tb_top;
  import hrfs_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_req;
  logic [31:0] t_now;
  logic [7:0]  slot_guess;
  logic [7:0]  bound_lo;
  logic [7:0]  bound_hi;
  int unsigned cfg_sync;
  int unsigned cfg_delay;

  hopping_rx_frame_sync_fsm dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  hrfs_link_checker link_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (64) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  function automatic in_item_t frame_poll(logic [31:0] t, logic [6:0] fifo, logic [7:0] len,
                                          logic [7:0] lo, logic [7:0] hi, logic [7:0] cnt,
                                          logic crc, logic idle, logic [7:0] rssi);
    in_item_t p;
    p.now_us = t;
    p.fifo_bytes = fifo;
    p.frame_length = len;
    p.frame_id_lo = lo;
    p.frame_id_hi = hi;
    p.frame_counter = cnt;
    p.crc_ok = crc;
    p.radio_idle = idle;
    p.link_rssi = rssi;
    return p;
  endfunction

  task automatic send_poll(input in_item_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_link();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(negedge clk);
  endtask

  task automatic make_poll(input int unsigned good_pct, output in_item_t p);
    int unsigned pick;
    int unsigned delta;
    pick = $urandom_range(0, 99);
    delta = 0;
    if (pick < 40) delta = $urandom_range(0, cfg_delay + 20);
    else if (pick < 70) delta = $urandom_range(0, cfg_sync + 10);
    else if (pick < 82) delta = cfg_sync + $urandom_range(0, 2) - 1;
    else if (pick < 94) delta = $urandom_range(0, cfg_sync * 12 + 10);
    else if (pick < 99) delta = $urandom_range(0, cfg_sync * 55 + 10);
    if (pick == 99) t_now = $urandom();
    else t_now = t_now + delta;

    p = frame_poll(t_now, 7'($urandom_range(FRAME_BYTES, 64)), FRAME_LEN_CODE, bound_lo,
                   bound_hi, slot_guess, 1'b1, ($urandom_range(0, 3) != 0),
                   8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < good_pct) begin
      if ($urandom_range(0, 6) == 0) p.frame_counter = 8'($urandom_range(0, 255));
      slot_guess = (p.frame_counter >= SLOT_WRAP - 8'd1) ? 8'd0 : p.frame_counter + 8'd1;
    end else begin
      case ($urandom_range(0, 4))
        0: p.fifo_bytes = 7'($urandom_range(0, FRAME_BYTES - 1));
        1: p.frame_length = 8'($urandom_range(0, 255));
        2: p.crc_ok = 1'b0;
        3: begin
          if ($urandom_range(0, 1) == 0) p.frame_id_lo ^= 8'($urandom_range(1, 255));
          else p.frame_id_hi ^= 8'($urandom_range(1, 255));
        end
        default: begin
          p.fifo_bytes = 7'($urandom_range(0, 64));
          p.frame_length = 8'($urandom_range(0, 255));
          p.frame_id_lo = 8'($urandom_range(0, 255));
          p.frame_id_hi = 8'($urandom_range(0, 255));
          p.frame_counter = 8'($urandom_range(0, 255));
          p.crc_ok = 1'($urandom_range(0, 1));
        end
      endcase
    end
  endtask

  task automatic run_phase(input int unsigned lo, input int unsigned hi,
                           input int unsigned sync, input int unsigned miss,
                           input int unsigned delay, input int unsigned thresh,
                           input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned good_pct, input int n, input bit hold,
                           input bit pause);
    in_item_t p;
    int       k;
    drain_link();
    write_reg(CFG_BOUND_ID_LO, lo);
    write_reg(CFG_BOUND_ID_HI, hi);
    write_reg(CFG_SYNC_TIMEOUT, sync);
    write_reg(CFG_MAX_MISSING, miss);
    write_reg(CFG_TELEM_DELAY, delay);
    write_reg(CFG_POWER_THRESH, thresh);
    cfg_we <= 1'b0;
    bound_lo = lo[7:0];
    bound_hi = hi[7:0];
    cfg_sync = sync;
    cfg_delay = delay;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (k = 0; k < n; k++) begin
      if (hold && k == n / 3) hold_req = 1'b1;
      if (pause && k == n / 2) drain_link();
      make_poll(good_pct, p);
      send_poll(p);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_BOUND_ID_LO;
    cfg_data = '0;
    rst_n = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    slot_guess = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_poll(frame_poll(32'd1000, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1, 8'd0));
    send_poll(frame_poll(32'd1100, 7'd19, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd0, 1'b1, 1'b1, 8'd7));
    send_poll(frame_poll(32'd1200, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd0, 1'b1, 1'b1, 8'd7));
    send_poll(frame_poll(32'd1300, 7'd64, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd5, 1'b1, 1'b1, 8'd9));
    send_poll(frame_poll(32'd1400, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd6, 1'b1, 1'b1, 8'd200));
    send_poll(frame_poll(32'd1500, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd7, 1'b1, 1'b1, 8'd3));
    send_poll(frame_poll(32'd2900, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd7, 1'b1, 1'b1, 8'd3));
    send_poll(frame_poll(32'd3000, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 8'd0));
    send_poll(frame_poll(32'd3100, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1, 8'd0));
    send_poll(frame_poll(32'd12401, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1, 8'd0));
    send_poll(frame_poll(32'd12500, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd200, 1'b1, 1'b1,
                         8'd1));
    send_poll(frame_poll(32'd12600, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd0, 1'b1, 1'b1, 8'd1));
    send_poll(frame_poll(32'd12700, 7'd20, 8'h12, 8'h00, 8'h00, 8'd1, 1'b1, 1'b1, 8'd1));
    send_poll(frame_poll(32'd12800, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd1, 1'b0, 1'b1, 8'd1));
    send_poll(frame_poll(32'd12900, 7'd20, FRAME_LEN_CODE, 8'h01, 8'h00, 8'd1, 1'b1, 1'b1, 8'd1));
    send_poll(frame_poll(32'd13000, 7'd20, FRAME_LEN_CODE, 8'h00, 8'h80, 8'd1, 1'b1, 1'b1, 8'd1));
    send_poll(frame_poll(32'd13100, 7'd40, FRAME_LEN_CODE, 8'h00, 8'h00, 8'd254, 1'b1, 1'b1,
                         8'd110));
    send_poll(frame_poll(32'd14600, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1, 8'd0));
    send_poll(frame_poll(32'hFFFF_FFFF, 7'd64, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'hFF));
    send_poll(frame_poll(32'h0000_0010, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 8'd0));
    send_poll(frame_poll(32'h0000_0010 + 32'd9000, 7'd0, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1,
                         8'd0));
    t_now = 32'h0000_0010 + 32'd9000;

    run_phase(8'h5A, 8'hC3, 9000, 50, 1500, 110, 0, 0, 65, 170, 1'b1, 1'b0);
    run_phase(8'hFF, 8'hFF, 1, 1, 0, 0, 84, 0, 55, 160, 1'b0, 1'b0);
    run_phase(8'h00, 8'h00, 1000000, 255, 9000, 255, 0, 84, 65, 160, 1'b0, 1'b1);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), 40, 3, 20, 128, 27, 27, 60, 170,
              1'b0, 1'b0);
    run_phase(8'h3C, 8'hA5, 0, 0, 5, 60, 0, 0, 50, 90, 1'b0, 1'b0);
    run_phase(8'h3C, 8'hA5, 0, 200, 5, 60, 84, 0, 0, 290, 1'b0, 1'b0);
    run_phase($urandom_range(0, 255), 200, 300, 2, 9000, 1, 0, 84, 65, 160, 1'b0, 1'b0);
    run_phase(8'h81, 8'h7E, 2000, 255, 100, 254, 27, 27, 65, 180, 1'b1, 1'b0);
    t_now = 32'hFFFF_F000;
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), 25, 5, 0, 110, 0, 0, 65, 150,
              1'b0, 1'b0);

    rx_stall_pct = 0;
    drain_link();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
